// ===== design/irc_line_field_tagger_core_assert.svh =====
// Assertion macros for the IRC line field tagger.
// Included by the modules that check their own logic; no other dependencies.
`ifndef IRC_LINE_FIELD_TAGGER_CORE_ASSERT_SVH
`define IRC_LINE_FIELD_TAGGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IRC_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error("irc_lft check failed");
`define IRC_ASSERT_NEXT(lbl, c, r, a, p) \
  lbl: assert property (@(posedge c) disable iff (r) a |=> p) else $error("irc_lft check failed");
`else
`define IRC_ASSERT(lbl, c, r, p)
`define IRC_ASSERT_NEXT(lbl, c, r, a, p)
`endif
`endif

// ===== design/irc_lft_pkg.sv =====
// Shared types, codes and keyword tables of the IRC line field tagger.
// No dependencies.
package irc_lft_pkg;

  localparam int COMMAND_SLOTS_DEF = 9;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CMD_WORDS         = 5;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CTCP  = 8'h01;

  localparam logic [2:0] TAG_PREFIX  = 3'd0;
  localparam logic [2:0] TAG_COMMAND = 3'd1;
  localparam logic [2:0] TAG_TARGET  = 3'd2;
  localparam logic [2:0] TAG_MESSAGE = 3'd3;
  localparam logic [2:0] TAG_DROP    = 3'd4;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ACTION = 3'd1;
  localparam logic [2:0] EV_MSG    = 3'd2;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_COMMAND,
    PH_TARGET,
    PH_MESSAGE
  } phase_t;

  typedef enum logic [1:0] {
    CT_NONE,
    CT_WORD,
    CT_OTHER,
    CT_ACTION
  } ctcp_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] tag;
    logic       nick;
    logic       eol;
    logic [2:0] ev;
    logic       nv;
    logic       retag;
  } word_t;

  // keywords stored left-justified, first char in the top byte
  function automatic logic [7:0] cmd_char(input logic [2:0] w, input logic [2:0] p);
    logic [55:0] s;
    case (w)
      3'd0:    s = "PRIVMSG";
      3'd1:    s = {"JOIN", 24'd0};
      3'd2:    s = {"PART", 24'd0};
      3'd3:    s = {"QUIT", 24'd0};
      3'd4:    s = {"NICK", 24'd0};
      default: s = 56'd0;
    endcase
    return s[55 - 8 * int'(p) -: 8];
  endfunction

  function automatic logic [3:0] cmd_len(input logic [2:0] w);
    return (w == 3'd0) ? 4'd7 : 4'd4;
  endfunction

  function automatic logic [7:0] act_char(input logic [2:0] p);
    logic [47:0] s;
    s = "ACTION";
    return (p < 3'd6) ? s[47 - 8 * int'(p) -: 8] : 8'd0;
  endfunction

endpackage

// ===== design/irc_lft_byte_if.sv =====
// Input channel of the tagger: one raw line byte and its end-of-line mark.
// No dependencies.
interface irc_lft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_line;

  modport source(output valid, output data_byte, output end_of_line, input ready);
  modport sink(input valid, input data_byte, input end_of_line, output ready);
endinterface

// ===== design/irc_lft_tag_if.sv =====
// Output channel of the tagger: one tagged byte with end-of-line status.
// No dependencies.
interface irc_lft_tag_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] field_tag;
  logic       in_nick;
  logic       line_done;
  logic [2:0] event_code;
  logic       nick_valid;

  modport source(output valid, output out_byte, output field_tag, output in_nick,
                 output line_done, output event_code, output nick_valid, input ready);
  modport sink(input valid, input out_byte, input field_tag, input in_nick,
               input line_done, input event_code, input nick_valid, output ready);
endinterface

// ===== design/irc_lft_front.sv =====
// Front end: accepts line bytes, tracks the line phase, command and CTCP match.
// Depends on irc_lft_pkg and irc_lft_byte_if.
module irc_lft_front #(
  parameter int COMMAND_SLOTS = irc_lft_pkg::COMMAND_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  irc_lft_byte_if.sink       byte_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output irc_lft_pkg::word_t push_word
);
  import irc_lft_pkg::*;

  localparam int         POS_LIMIT = (COMMAND_SLOTS > 15) ? 15 : COMMAND_SLOTS;
  localparam logic [3:0] POS_LIM   = POS_LIMIT[3:0];

  phase_t     phase, phase_next, ph_eff;
  logic [3:0] cmd_pos, cmd_pos_next;
  logic [4:0] cmd_mask, cmd_mask_next;
  logic [2:0] ct_pos, ct_pos_next;
  ctcp_t      ct_state, ct_state_next, ct_fin;
  logic       ct_match, ct_match_next;
  logic       prefix_present, prefix_next;
  logic       bang_seen, bang_next;
  logic       prev_valid, prev_space;

  logic [7:0] b;
  logic       eol, acc;
  logic [2:0] tag, ev;
  logic       nick, retag;

  assign b              = byte_ch.data_byte;
  assign eol            = byte_ch.end_of_line;
  assign byte_ch.ready  = push_ready;
  assign push_valid     = byte_ch.valid;
  assign acc            = byte_ch.valid && push_ready;

  always_comb begin
    phase_next    = phase;
    cmd_pos_next  = cmd_pos;
    cmd_mask_next = cmd_mask;
    ct_pos_next   = ct_pos;
    ct_state_next = ct_state;
    ct_match_next = ct_match;
    prefix_next   = prefix_present;
    bang_next     = bang_seen;
    tag           = TAG_DROP;
    nick          = 1'b0;
    retag         = 1'b0;
    ev            = EV_NONE;

    ph_eff = (phase == PH_START && b != CH_COLON) ? PH_COMMAND : phase;

    case (ph_eff)
      PH_START: begin
        phase_next = PH_PREFIX;
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          phase_next = PH_COMMAND;
        end else begin
          tag         = TAG_PREFIX;
          prefix_next = 1'b1;
          nick        = !bang_seen && b != CH_BANG;
          if (b == CH_BANG) bang_next = 1'b1;
        end
      end
      PH_COMMAND: begin
        if (b == CH_SPACE) begin
          phase_next = PH_TARGET;
        end else begin
          tag = TAG_COMMAND;
          for (int w = 0; w < CMD_WORDS; w++) begin
            if (!(cmd_pos < cmd_len(3'(w)) && b == cmd_char(3'(w), cmd_pos[2:0])))
              cmd_mask_next[w] = 1'b0;
          end
          if (cmd_pos < POS_LIM) cmd_pos_next = cmd_pos + 4'd1;
          phase_next = PH_COMMAND;
        end
      end
      PH_TARGET: begin
        if (b == CH_COLON && prev_valid && prev_space) begin
          retag      = 1'b1;
          phase_next = PH_MESSAGE;
        end else begin
          tag = TAG_TARGET;
        end
      end
      PH_MESSAGE: begin
        tag = TAG_MESSAGE;
        case (ct_state)
          CT_NONE: begin
            if (b == CH_CTCP) begin
              ct_state_next = CT_WORD;
              ct_pos_next   = 3'd0;
              ct_match_next = 1'b1;
            end else begin
              ct_state_next = CT_OTHER;
            end
          end
          CT_WORD: begin
            if (b == CH_SPACE || b == CH_CTCP) begin
              ct_state_next = (ct_match && ct_pos == 3'd6) ? CT_ACTION : CT_OTHER;
            end else begin
              if (!(ct_pos < 3'd6 && b == act_char(ct_pos))) ct_match_next = 1'b0;
              if (ct_pos < 3'd7) ct_pos_next = ct_pos + 3'd1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    if (ct_state_next == CT_WORD)
      ct_fin = (ct_match_next && ct_pos_next == 3'd6) ? CT_ACTION : CT_OTHER;
    else
      ct_fin = ct_state_next;

    if (eol) begin
      if (ct_fin == CT_ACTION) begin
        ev = EV_ACTION;
      end else begin
        for (int w = CMD_WORDS - 1; w >= 0; w--) begin
          if (cmd_mask_next[w] && cmd_pos_next == cmd_len(3'(w))) ev = EV_MSG + 3'(w);
        end
      end
    end

    push_word.data  = b;
    push_word.tag   = tag;
    push_word.nick  = nick;
    push_word.eol   = eol;
    push_word.ev    = ev;
    push_word.nv    = eol && prefix_next && ev != EV_NONE;
    push_word.retag = retag;
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && eol)) begin
      phase          <= PH_START;
      cmd_pos        <= 4'd0;
      cmd_mask       <= 5'h1F;
      ct_pos         <= 3'd0;
      ct_state       <= CT_NONE;
      ct_match       <= 1'b1;
      prefix_present <= 1'b0;
      bang_seen      <= 1'b0;
      prev_valid     <= 1'b0;
      prev_space     <= 1'b0;
    end else if (acc) begin
      phase          <= phase_next;
      cmd_pos        <= cmd_pos_next;
      cmd_mask       <= cmd_mask_next;
      ct_pos         <= ct_pos_next;
      ct_state       <= ct_state_next;
      ct_match       <= ct_match_next;
      prefix_present <= prefix_next;
      bang_seen      <= bang_next;
      prev_valid     <= 1'b1;
      prev_space     <= (b == CH_SPACE);
    end
  end

endmodule

// ===== design/irc_lft_queue.sv =====
// Short word queue between front and back end, flip-flop storage.
// Depends on irc_lft_pkg and the assertion header.
`include "irc_line_field_tagger_core_assert.svh"
module irc_lft_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  irc_lft_pkg::word_t push_word,
  output logic               pop_valid,
  input  logic               pop_ready,
  output irc_lft_pkg::word_t pop_word
);
  import irc_lft_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  word_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_word   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `IRC_ASSERT(a_q_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH))
  `IRC_ASSERT(a_q_ptrs, clk, rst, PTR_W'(wr_ptr - rd_ptr) == count[PTR_W-1:0])
  `IRC_ASSERT_NEXT(a_q_inc, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== design/irc_lft_back.sv =====
// Back end: holds one byte, applies separator retagging, emits tagged words.
// Depends on irc_lft_pkg, irc_lft_tag_if and the assertion header.
`include "irc_line_field_tagger_core_assert.svh"
module irc_lft_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  irc_lft_pkg::word_t pop_word,
  irc_lft_tag_if.source      tag_ch
);
  import irc_lft_pkg::*;

  word_t      held, pend;
  logic       held_valid, pend_valid;
  logic       o_valid, o_nick, o_done, o_nv;
  logic [7:0] o_byte;
  logic [2:0] o_tag, o_ev;
  logic       slot_free, pop;

  // while the final word drains, a first byte of the next line can still be held
  assign slot_free = !o_valid || tag_ch.ready;
  assign pop_ready = slot_free && !(pend_valid && pop_word.eol);
  assign pop       = pop_valid && pop_ready;

  assign tag_ch.valid      = o_valid;
  assign tag_ch.out_byte   = o_byte;
  assign tag_ch.field_tag  = o_tag;
  assign tag_ch.in_nick    = o_nick;
  assign tag_ch.line_done  = o_done;
  assign tag_ch.event_code = o_ev;
  assign tag_ch.nick_valid = o_nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        o_valid    <= 1'b1;
        o_byte     <= pend.data;
        o_tag      <= pend.tag;
        o_nick     <= pend.nick;
        o_done     <= 1'b1;
        o_ev       <= pend.ev;
        o_nv       <= pend.nv;
        pend_valid <= 1'b0;
        if (pop) begin
          held       <= pop_word;
          held_valid <= 1'b1;
        end
      end else if (pop && held_valid) begin
        o_valid <= 1'b1;
        o_byte  <= held.data;
        o_tag   <= pop_word.retag ? TAG_DROP : held.tag;
        o_nick  <= held.nick;
        o_done  <= 1'b0;
        o_ev    <= EV_NONE;
        o_nv    <= 1'b0;
        if (pop_word.eol) begin
          pend       <= pop_word;
          pend_valid <= 1'b1;
          held_valid <= 1'b0;
        end else begin
          held <= pop_word;
        end
      end else if (pop && pop_word.eol) begin
        o_valid <= 1'b1;
        o_byte  <= pop_word.data;
        o_tag   <= pop_word.tag;
        o_nick  <= pop_word.nick;
        o_done  <= 1'b1;
        o_ev    <= pop_word.ev;
        o_nv    <= pop_word.nv;
      end else if (pop) begin
        held       <= pop_word;
        held_valid <= 1'b1;
        o_valid    <= 1'b0;
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  `IRC_ASSERT(a_b_ev_last, clk, rst, o_valid && !o_done |-> o_ev == EV_NONE && !o_nv)
  `IRC_ASSERT(a_b_done_empty, clk, rst, o_valid && o_done |-> !pend_valid)
  `IRC_ASSERT(a_b_pend_hold, clk, rst, pend_valid |-> !held_valid)

endmodule

// ===== design/irc_line_field_tagger_core.sv =====
// IRC line field tagger, top level: front end, word queue and back end.
// Depends on irc_lft_pkg, irc_lft_byte_if, irc_lft_tag_if and the three submodules.
//
// Usage:
//   byte_ch takes one raw byte of an IRC line per word; end_of_line marks the
//   last byte. tag_ch returns each byte tagged prefix, command, target,
//   message or dropped separator, with the nick flag. The last word of a line
//   has line_done set and carries event_code and nick_valid.
//   A byte is held until the next byte of its line arrives, then reaches
//   tag_ch once that byte is taken (queue register, then output register).
//   The final byte waits in a pending register and follows its predecessor.
//   Throughput: one byte per cycle while tag_ch is ready. The two words
//   released by a final byte leave while the first byte of the next line is
//   taken; only a one-byte line right after a line end waits until the pending final word has left.
//   A four-word queue lets byte_ch keep flowing while tag_ch stalls; when it
//   fills, byte_ch.ready drops until the receiver takes words again.
//   Reset (rst, synchronous) empties the queue and the held byte and puts
//   the parser at start of line; it is ready as soon as reset is released.
//   COMMAND_SLOTS sets where the command position counter saturates (at most 15).
module irc_line_field_tagger_core #(
  parameter int COMMAND_SLOTS = irc_lft_pkg::COMMAND_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  irc_lft_byte_if.sink  byte_ch,
  irc_lft_tag_if.source tag_ch
);
  import irc_lft_pkg::*;

  word_t push_word, pop_word;
  logic  push_valid, push_ready, pop_valid, pop_ready;

  irc_lft_front #(
    .COMMAND_SLOTS(COMMAND_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_word (push_word)
  );

  irc_lft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_word (push_word),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word)
  );

  irc_lft_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_word (pop_word),
    .tag_ch   (tag_ch)
  );

endmodule

// ===== tb/sv/tb_irc_line_field_tagger_core.sv =====
`timescale 1ns / 1ps
// Testbench of irc_line_field_tagger_core: IRC lines in, tagged words out, checked in order
// against a line tracker kept in step with every accepted byte.
// Depends on irc_lft_pkg, irc_lft_byte_if, irc_lft_tag_if and the tagger core.

import irc_lft_pkg::*;

localparam string ACTION_WORD = "ACTION";

typedef struct packed {
  logic [7:0] data;
  logic [2:0] tag;
  logic       nick;
  logic       done;
  logic [2:0] ev;
  logic       nv;
} tag_word_t;

function automatic string irc_keyword(int w);
  case (w)
    0:       return "PRIVMSG";
    1:       return "JOIN";
    2:       return "PART";
    3:       return "QUIT";
    default: return "NICK";
  endcase
endfunction

class field_tag_tracker;
  tag_word_t   pending_tags[$];
  int unsigned errors;
  int unsigned slot_cap;

  phase_t      ph;
  logic [7:0]  h_byte;
  logic        h_valid;
  logic        h_space;
  logic        h_nick;
  logic [2:0]  h_tag;
  logic [3:0]  cmd_pos;
  logic [4:0]  cmd_mask;
  logic [2:0]  ct_pos;
  ctcp_t       ct;
  logic        ct_match;
  logic        pfx_seen;
  logic        bang_seen;

  function new(int slots);
    slot_cap = (slots > 15) ? 15 : slots;
    errors = 0;
    start_line();
  endfunction

  function void start_line();
    ph = PH_START;
    h_byte = 8'h00;
    h_valid = 1'b0;
    h_space = 1'b0;
    h_nick = 1'b0;
    h_tag = TAG_PREFIX;
    cmd_pos = 4'd0;
    cmd_mask = 5'h1F;
    ct_pos = 3'd0;
    ct = CT_NONE;
    ct_match = 1'b1;
    pfx_seen = 1'b0;
    bang_seen = 1'b0;
  endfunction

  function void cmd_step(logic [7:0] b);
    string kw;
    for (int w = 0; w < CMD_WORDS; w++) begin
      kw = irc_keyword(w);
      if (!(cmd_pos < kw.len() && b == 8'(kw[cmd_pos]))) cmd_mask[w] = 1'b0;
    end
    if (cmd_pos < slot_cap) cmd_pos++;
  endfunction

  function void ctcp_word_end();
    ct = (ct_match && ct_pos == 3'd6) ? CT_ACTION : CT_OTHER;
  endfunction

  function void ctcp_step(logic [7:0] b);
    string act;
    act = ACTION_WORD;
    case (ct)
      CT_NONE: begin
        if (b == CH_CTCP) begin
          ct = CT_WORD;
          ct_pos = 3'd0;
          ct_match = 1'b1;
        end else begin
          ct = CT_OTHER;
        end
      end
      CT_WORD: begin
        if (b == CH_SPACE || b == CH_CTCP) begin
          ctcp_word_end();
        end else begin
          if (!(ct_pos < 3'd6 && b == 8'(act[ct_pos]))) ct_match = 1'b0;
          if (ct_pos < 3'd7) ct_pos++;
        end
      end
      default: ;
    endcase
  endfunction

  function void take_byte(logic [7:0] b, logic last);
    logic [2:0] tg;
    logic       nk;
    logic [2:0] ev;
    logic       opened;
    string      kw;
    tag_word_t  w;
    tg = TAG_DROP;
    nk = 1'b0;
    opened = 1'b0;
    if (ph == PH_START) begin
      if (b == CH_COLON) begin
        ph = PH_PREFIX;
        opened = 1'b1;
      end else begin
        ph = PH_COMMAND;
      end
    end
    if (!opened) begin
      case (ph)
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            ph = PH_COMMAND;
          end else begin
            tg = TAG_PREFIX;
            pfx_seen = 1'b1;
            nk = !bang_seen && b != CH_BANG;
            if (b == CH_BANG) bang_seen = 1'b1;
          end
        end
        PH_COMMAND: begin
          if (b == CH_SPACE) begin
            ph = PH_TARGET;
          end else begin
            tg = TAG_COMMAND;
            cmd_step(b);
          end
        end
        PH_TARGET: begin
          if (b == CH_COLON && h_valid && h_space) begin
            h_tag = TAG_DROP;
            ph = PH_MESSAGE;
          end else begin
            tg = TAG_TARGET;
          end
        end
        default: begin
          tg = TAG_MESSAGE;
          ctcp_step(b);
        end
      endcase
    end
    if (h_valid) begin
      w = '{data: h_byte, tag: h_tag, nick: h_nick, done: 1'b0, ev: EV_NONE, nv: 1'b0};
      pending_tags.push_back(w);
    end
    if (last) begin
      ev = EV_NONE;
      if (ct == CT_WORD) ctcp_word_end();
      if (ct == CT_ACTION) begin
        ev = EV_ACTION;
      end else begin
        for (int k = 0; k < CMD_WORDS; k++) begin
          kw = irc_keyword(k);
          if (ev == EV_NONE && cmd_mask[k] && cmd_pos == kw.len()) ev = EV_MSG + 3'(k);
        end
      end
      w = '{data: b, tag: tg, nick: nk, done: 1'b1, ev: ev,
            nv: pfx_seen && ev != EV_NONE};
      pending_tags.push_back(w);
      start_line();
    end else begin
      h_byte = b;
      h_tag = tg;
      h_nick = nk;
      h_space = (b == CH_SPACE);
      h_valid = 1'b1;
    end
  endfunction

  function void diff(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function void check_word(tag_word_t got);
    tag_word_t want;
    if (pending_tags.size() == 0) begin
      errors++;
      if (errors <= 100)
        $display("%0t: unexpected word, expected none got %0h", $time, got);
      return;
    end
    want = pending_tags.pop_front();
    diff("out_byte", want.data, got.data);
    diff("field_tag", want.tag, got.tag);
    diff("in_nick", want.nick, got.nick);
    diff("line_done", want.done, got.done);
    diff("event_code", want.ev, got.ev);
    diff("nick_valid", want.nv, got.nv);
  endfunction
endclass

module tb_irc_line_field_tagger_core;

  localparam int CMD_SLOTS   = COMMAND_SLOTS_DEF;
  localparam int ITEM_TARGET = 1850;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;

  irc_lft_byte_if byte_ch();
  irc_lft_tag_if  tag_ch();

  irc_line_field_tagger_core #(.COMMAND_SLOTS(CMD_SLOTS)) dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .tag_ch  (tag_ch)
  );

  field_tag_tracker tracker = new(CMD_SLOTS);

  logic [7:0] line_bytes[$];
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         words_seen = 0;
  bit         rx_hold = 1'b0;
  int         idle_cycles = 0;

  always #5 clk = ~clk;

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
  endtask

  // seps: mix in spaces, colons and arbitrary bytes
  task automatic add_text(int n, bit seps);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (seps) begin
        case ($urandom_range(0, 7))
          0:       c = CH_SPACE;
          1:       c = CH_COLON;
          2:       c = 8'($urandom_range(0, 255));
          default: c = 8'($urandom_range(33, 126));
        endcase
      end else begin
        c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(33, 126));
      end
      line_bytes.push_back(c);
    end
  endtask

  task automatic add_word(string base);
    int    sel;
    string kw;
    kw = base;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      add_text($urandom_range(1, 12), 0);
    end else begin
      if (sel == 1) kw = kw.substr(0, kw.len() - 2);
      if (sel == 2) kw[$urandom_range(0, kw.len() - 1)] = 8'($urandom_range(97, 122));
      add_str(kw);
      if (sel == 3) add_text($urandom_range(1, 6), 0);
    end
  endtask

  task automatic build_line();
    line_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      for (int i = $urandom_range(1, 8); i > 0; i--)
        line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 1)) begin
      line_bytes.push_back(CH_COLON);
      add_text($urandom_range(0, 5), 0);
      if ($urandom_range(0, 1)) begin
        line_bytes.push_back(CH_BANG);
        add_text($urandom_range(0, 5), 0);
      end
      if ($urandom_range(0, 11) == 0) return;
      line_bytes.push_back(CH_SPACE);
    end
    add_word(irc_keyword($urandom_range(0, CMD_WORDS - 1)));
    if ($urandom_range(0, 11) == 0) return;
    line_bytes.push_back(CH_SPACE);
    if ($urandom_range(0, 4) != 0) begin
      add_text($urandom_range(0, 8), 1);
      if ($urandom_range(0, 5) == 0) return;
      line_bytes.push_back(CH_SPACE);
    end
    line_bytes.push_back(CH_COLON);
    if ($urandom_range(0, 1)) begin
      line_bytes.push_back(CH_CTCP);
      add_word(ACTION_WORD);
      case ($urandom_range(0, 3))
        0:       return;
        1:       line_bytes.push_back(CH_CTCP);
        2:       line_bytes.push_back(CH_SPACE);
        default: ;
      endcase
    end
    add_text($urandom_range(0, 10), 1);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.end_of_line <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.take_byte(b, last);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !rx_hold) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  initial begin
    rst                 <= 1'b1;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= 8'h00;
    byte_ch.end_of_line <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 30);

    // single-byte line at the top of the byte range
    line_bytes.delete();
    line_bytes.push_back(8'hFF);
    send_line();
    // prefix with bang, message right after command, CTCP action cut by end of line
    line_bytes.delete();
    add_str(":n!u JOIN :");
    line_bytes.push_back(CH_CTCP);
    add_str(ACTION_WORD);
    send_line();
    // line ends inside the prefix
    line_bytes.delete();
    add_str(":x");
    send_line();
    // spaces and colons in the target before the separator
    line_bytes.delete();
    add_str("NICK a:b c :m");
    line_bytes.push_back(8'h00);
    send_line();

    while (bytes_sent < ITEM_TARGET) begin
      build_line();
      send_line();
    end
    byte_ch.valid <= 1'b0;

    while (tracker.pending_tags.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_irc_line_field_tagger_core OK");
    end else begin
      $display("tb_irc_line_field_tagger_core NOT OK");
    end
    $finish;
  end

  // receiver: sample the handshake at the edge, then pick next ready
  initial begin
    tag_word_t got;
    int        cyc;
    int        mode;
    int        hold_left;
    bit        hold_done;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    tag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tag_ch.valid && tag_ch.ready) begin
        got.data = tag_ch.out_byte;
        got.tag  = tag_ch.field_tag;
        got.nick = tag_ch.in_nick;
        got.done = tag_ch.line_done;
        got.ev   = tag_ch.event_code;
        got.nv   = tag_ch.nick_valid;
        tracker.check_word(got);
        words_seen++;
      end
      if (words_seen >= 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        rx_hold = 1'b1;
      end
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        tag_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) rx_hold = 1'b0;
      end else begin
        case (mode)
          0:       tag_ch.ready <= 1'b1;
          1:       tag_ch.ready <= 1'($urandom_range(0, 1));
          2:       tag_ch.ready <= (cyc % 3 == 0);
          default: tag_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (tag_ch.valid && tag_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_irc_line_field_tagger_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
